/* sv/swc_pkg.sv */
// Shared types, character codes and classification functions for the
// source whitespace compactor. No dependencies.
package swc_pkg;

	// Kept-character counter width
	localparam int COUNT_BITS = 16;
	localparam int LIMIT_BITS = 16;

	// Result queue geometry
	localparam int MAX_RES   = 3;
	localparam int QDEPTH    = 8;
	localparam int QPTR_BITS = $clog2(QDEPTH);
	localparam int QCNT_BITS = $clog2(QDEPTH + 1);

	// Configuration port
	localparam int PADDR_BITS = 3;
	localparam int PDATA_BITS = 32;
	localparam logic [0:0] REG_MAX_LENGTH = 1'b0;
	localparam logic [LIMIT_BITS-1:0] MAX_LENGTH_RESET = 16'd4096;

	// Character codes
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_EQUAL  = 8'h3D;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_QUOTE  = 8'h27;

	// One result transaction
	typedef struct packed {
		logic [7:0] sym;
		logic       term;
		logic       ovf;
	} result_t;

	// Results produced by one accepted input, in order
	typedef struct packed {
		logic [1:0]              n;
		result_t [MAX_RES-1:0]   slot;
	} push_t;

	// Following character drops a space after these
	function automatic logic after_drops_space(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_SEMI) || (c == CH_RPAREN) ||
			(c == CH_COLON) || (c == CH_LPAREN) || (c == CH_PLUS) ||
			(c == CH_MINUS) || (c == CH_EQUAL) || (c == CH_STAR) ||
			(c == CH_BANG) || (c == CH_QUOTE);
	endfunction

	// These characters swallow a held space in front of them
	function automatic logic absorbs_space(input logic [7:0] c);
		return (c == CH_RPAREN) || (c == CH_LPAREN) || (c == CH_PLUS) ||
			(c == CH_MINUS) || (c == CH_EQUAL) || (c == CH_STAR) ||
			(c == CH_BANG) || (c == CH_QUOTE);
	endfunction

endpackage

/* sv/source_whitespace_compactor_top.sv */
// Top level of the source whitespace compactor: configuration register,
// front end and result queue. Depends on swc_pkg, swc_front, swc_queue.
//
//   channel   handshake                 payload
//   input     in_valid / in_stall       symbol, end_of_text
//   output    out_valid / out_stall     out_symbol, is_terminator, overflow
//   config    APB psel/penable/pready   paddr, pwdata, prdata
//
// One input transaction per cycle while the eight-entry result queue has
// room for three results; output drains one result per cycle while
// out_stall is low, so the sustained rate is one item per cycle for items
// with at most one result. Results are registered in the queue, then the
// output register. Reset clears run state, the queue and sets max_length
// to 4096. in_stall rises while the queue holds more than five results.
module source_whitespace_compactor_top import swc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [7:0]            symbol,
	input  logic                  end_of_text,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [7:0]            out_symbol,
	output logic                  is_terminator,
	output logic                  overflow,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PADDR_BITS-1:0] paddr,
	input  logic [PDATA_BITS-1:0] pwdata,
	output logic [PDATA_BITS-1:0] prdata,
	output logic                  pready
);

	logic [LIMIT_BITS-1:0] max_length_q;
	logic                  room;
	push_t                 push;
	result_t               out_res;

	assign pready = 1'b1;

	// Configuration register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_length_q <= MAX_LENGTH_RESET;
		end else if (psel && penable && pwrite && paddr[2] == REG_MAX_LENGTH) begin
			max_length_q <= pwdata[LIMIT_BITS-1:0];
		end
	end

	// Register read
	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_MAX_LENGTH) begin
			prdata = PDATA_BITS'(max_length_q);
		end
	end

	swc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.symbol      (symbol),
		.end_of_text (end_of_text),
		.room        (room),
		.max_length  (max_length_q),
		.in_stall    (in_stall),
		.push        (push)
	);

	swc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_res   (out_res)
	);

	assign out_symbol    = out_res.sym;
	assign is_terminator = out_res.term;
	assign overflow      = out_res.ovf;

endmodule

/* sv/swc_front.sv */
// Front end: accepts characters, classifies them, tracks run state and
// produces up to three results per transaction. Depends on swc_pkg.
module swc_front import swc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic [7:0]            symbol,
	input  logic                  end_of_text,
	input  logic                  room,
	input  logic [LIMIT_BITS-1:0] max_length,
	output logic                  in_stall,
	output push_t                 push
);

	logic [7:0]            prev_q;
	logic                  held_q;
	logic [COUNT_BITS-1:0] cnt_q;
	logic                  drop_q;

	logic [7:0]            prev_n;
	logic                  held_n;
	logic [COUNT_BITS-1:0] cnt_n;
	logic                  drop_n;
	logic                  accept;

	result_t               cand [4];
	logic [3:0]            en;

	assign in_stall = !room;
	assign accept   = in_valid && room;

	// Classify the item and work out next state and candidate results
	always_comb begin
		logic                  absorb;
		logic                  ovf;
		logic [COUNT_BITS-1:0] cnt_inc;
		prev_n = prev_q;
		held_n = held_q;
		cnt_n  = cnt_q;
		drop_n = drop_q;
		en     = '0;
		absorb = 1'b0;
		ovf    = 1'b0;
		cnt_inc = cnt_q + COUNT_BITS'(1);
		cand[0] = '{sym: CH_SPACE, term: 1'b0, ovf: 1'b0};
		cand[1] = '{sym: symbol,   term: 1'b0, ovf: 1'b0};
		cand[2] = '{sym: CH_SPACE, term: 1'b0, ovf: 1'b0};
		cand[3] = '{sym: CH_NUL,   term: 1'b1, ovf: 1'b0};
		if (end_of_text) begin
			// Flush held space and close the run
			if (!drop_q) begin
				en[0] = held_q;
				en[3] = 1'b1;
			end
			prev_n = CH_NUL;
			held_n = 1'b0;
			cnt_n  = '0;
			drop_n = 1'b0;
		end else if (drop_q || symbol == CH_NL || symbol == CH_NUL) begin
			// Ignore
		end else if (symbol == CH_SPACE && after_drops_space(prev_q)) begin
			// Redundant space
		end else begin
			absorb = held_q && absorbs_space(symbol);
			en[0]  = held_q && !absorb;
			cnt_n  = absorb ? cnt_q : cnt_inc;
			prev_n = symbol;
			held_n = (symbol == CH_SPACE);
			en[1]  = (symbol != CH_SPACE);
			ovf    = (32'(cnt_n) >= 32'(max_length)) || (&cnt_n);
			if (ovf) begin
				en[2]   = held_n;
				held_n  = 1'b0;
				en[3]   = 1'b1;
				cand[3].ovf = 1'b1;
				drop_n  = 1'b1;
			end
		end
	end

	// Pack enabled candidates into consecutive slots
	always_comb begin
		logic [2:0] k;
		k = '0;
		push.slot = '0;
		for (int i = 0; i < 4; i++) begin
			if (en[i] && k < 3'(MAX_RES)) begin
				push.slot[k[1:0]] = cand[i];
				k = k + 3'd1;
			end
		end
		push.n = accept ? k[1:0] : 2'd0;
	end

	// Advance run state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= CH_NUL;
			held_q <= 1'b0;
			cnt_q  <= '0;
			drop_q <= 1'b0;
		end else if (accept) begin
			prev_q <= prev_n;
			held_q <= held_n;
			cnt_q  <= cnt_n;
			drop_q <= drop_n;
		end
	end

endmodule

/* sv/swc_queue.sv */
// Result queue and output register: takes up to three results per cycle
// from the front end and hands them out one per cycle while out_stall is low. Depends on swc_pkg.
module swc_queue import swc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  push_t   push,
	output logic    room,
	output logic    out_valid,
	input  logic    out_stall,
	output result_t out_res
);

	result_t              mem_q [QDEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QCNT_BITS-1:0] count_q;
	logic                 out_valid_q;
	result_t              out_q;
	logic                 pop;

	assign room      = count_q <= QCNT_BITS'(QDEPTH - MAX_RES);
	assign pop       = (count_q != '0) && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign out_res   = out_q;

	// Store pushed results
	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_RES; i++) begin
			if (2'(i) < push.n) begin
				mem_q[wr_ptr_q + QPTR_BITS'(i)] <= push.slot[i];
			end
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPTR_BITS'(push.n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_BITS'(1);
			end
			count_q <= count_q + QCNT_BITS'(push.n) - QCNT_BITS'(pop);
		end
	end

	// Output register: load on pop, drop valid once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= mem_q[rd_ptr_q];
		end
	end

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_BITS'(QDEPTH))
		else $error("result queue over capacity");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push.n != 2'd0) |-> room)
		else $error("push without room");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != QCNT_BITS'(QDEPTH)) |-> (QPTR_BITS'(count_q) == wr_ptr_q - rd_ptr_q))
		else $error("fill count disagrees with pointers");
	a_pop_loads: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> out_valid_q)
		else $error("popped result not presented");
`endif

endmodule
